// File: rtl/core/vgrt_pkg.sv
// Shared types and constants for the voxel grid ray traversal block.
// Used by vgrt_div and voxel_grid_ray_traversal_top; depends on nothing.
package vgrt_pkg;

  localparam int unsigned NUM_W  = 33;   // dividend width of the shared divider
  localparam int unsigned TIME_W = 48;   // crossing time width

  localparam logic [TIME_W-1:0] TIME_ALL = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] TIME_FIN = {{(TIME_W-1){1'b1}}, 1'b0};

  localparam logic [30:0] SIZE_RESET = 31'd6554;

  typedef struct packed {
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] start_z;
    logic [31:0] end_x;
    logic [31:0] end_y;
    logic [31:0] end_z;
  } in_t;

  typedef struct packed {
    logic [31:0] voxel_x;
    logic [31:0] voxel_y;
    logic [31:0] voxel_z;
    logic        last_beat;
    logic        truncated;
  } out_t;

  typedef struct packed {
    logic             start;
    logic             frac_en;
    logic [NUM_W-1:0] num;
    logic [31:0]      den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quot;
    logic [31:0]       rem;
  } div_rsp_t;

endpackage

// File: rtl/core/voxel_grid_ray_traversal_top.sv
// Voxel grid ray traversal top level: setup sequencer, voxel walk, output register.
// Depends on vgrt_pkg and vgrt_div.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one ray segment per
//   beat; in_stall_o stays high from acceptance until the last voxel of that ray
//   has been loaded into the output register.
//   Output channel (out_valid_o / out_stall_i / out_data_o) gives one beat per
//   visited voxel; last_beat marks the final beat of a ray and truncated flags a
//   walk cut short by MAX_VOXELS.
//   cfg_we_i / cfg_wdata_i write voxel_size; write it only while the block is idle.
// Sequence:
//   Setup runs up to twelve divisions on the one shared divider, one quotient bit
//   per cycle; an index floor is an integer quotient, a crossing time carries
//   TIME_FRAC_BITS fraction bits. An axis with zero direction skips its two time divisions.
//   Each voxel then makes three passes through the shared corner multiplier and
//   one push into the output register. A stalled output holds its beat; the walk
//   waits at the push step.
// Reset: output empty, voxel_size back to 6554, block ready for a ray.
module voxel_grid_ray_traversal_top #(
  parameter int unsigned MAX_VOXELS     = 64,
  parameter int unsigned TIME_FRAC_BITS = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  vgrt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output vgrt_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [30:0]    cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(MAX_VOXELS + 1);
  localparam int unsigned TW    = vgrt_pkg::TIME_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_MUL   = 5'b01000,
    S_PUSH  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    OP_CUR  = 2'd0,
    OP_FIN  = 2'd1,
    OP_NEXT = 2'd2,
    OP_STEP = 2'd3
  } op_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [1:0] ax_q, ax_d;

  logic [30:0] size_q;
  logic [30:0] size;

  logic [2:0][31:0] s_q, e_q;
  logic [2:0][31:0] cur_q, cur_d, fin_q, fin_d;
  logic [2:0][TW-1:0] nc_q, nc_d, cs_q, cs_d;
  logic [2:0] sgn_q, sgn_d, adj_q, adj_d;
  logic [31:0] r_q, r_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [2:0][31:0] corner_q, corner_d;

  vgrt_pkg::out_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  vgrt_pkg::div_req_t div_req;
  vgrt_pkg::div_rsp_t div_rsp;

  vgrt_div #(
    .FRAC_BITS(TIME_FRAC_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign size = (size_q == '0) ? 31'd1 : size_q;

  // per-axis values for the axis under setup
  logic [31:0] sa, ea, va;
  logic [32:0] d33, ad33;
  logic        d_zero, d_neg;
  logic [32:0] abs_v;

  always_comb begin
    sa     = s_q[ax_q];
    ea     = e_q[ax_q];
    d33    = {ea[31], ea} - {sa[31], sa};
    d_neg  = d33[32];
    d_zero = (d33 == '0);
    ad33   = d_neg ? (~d33 + 33'd1) : d33;
    va     = (op_q == OP_FIN) ? ea : sa;
    abs_v  = va[31] ? (~{va[31], va} + 33'd1) : {1'b0, va};
  end

  // floor division result from the divider
  logic [31:0] fl_q, fl_r;
  logic        rem_nz;

  always_comb begin
    rem_nz = (div_rsp.rem != '0);
    if (va[31]) begin
      fl_q = (~div_rsp.quot[31:0] + 32'd1) - {31'd0, rem_nz};
      fl_r = rem_nz ? ({1'b0, size} - div_rsp.rem) : div_rsp.rem;
    end else begin
      fl_q = div_rsp.quot[31:0];
      fl_r = div_rsp.rem;
    end
  end

  always_comb begin
    div_req.start   = 1'b0;
    div_req.frac_en = 1'b0;
    div_req.num     = abs_v;
    div_req.den     = {1'b0, size};
    if (state_q == S_ISSUE) begin
      unique case (op_q)
        OP_CUR, OP_FIN: begin
          div_req.start = 1'b1;
        end
        OP_NEXT: begin
          div_req.start   = !d_zero;
          div_req.frac_en = 1'b1;
          div_req.num     = sgn_q[ax_q] ? ({2'b0, size} - {1'b0, r_q})
                                        : ({2'b0, size} + {1'b0, r_q});
          div_req.den     = ad33[31:0];
        end
        OP_STEP: begin
          div_req.start   = 1'b1;
          div_req.frac_en = 1'b1;
          div_req.num     = {2'b0, size};
          div_req.den     = ad33[31:0];
        end
        default: ;
      endcase
    end
  end

  // shared corner multiplier with saturation
  logic signed [63:0] prod;
  logic [31:0]        corner_sat;

  always_comb begin
    prod = $signed(cur_q[ax_q]) * $signed({1'b0, size});
    if (!prod[63] && (prod[62:31] != '0)) begin
      corner_sat = 32'h7FFF_FFFF;
    end else if (prod[63] && (prod[62:31] != '1)) begin
      corner_sat = 32'h8000_0000;
    end else begin
      corner_sat = prod[31:0];
    end
  end

  // walk decisions
  logic       at_end, neg_any, first_adj, last_now;
  logic [1:0] pick;
  logic [TW:0] t_sum;

  always_comb begin
    at_end    = (cur_q[0] == fin_q[0]) && (cur_q[1] == fin_q[1]) && (cur_q[2] == fin_q[2]);
    neg_any   = |adj_q;
    first_adj = (cnt_q == '0) && neg_any;
    last_now  = !first_adj && (at_end || (cnt_q + CNT_W'(1) == CNT_W'(MAX_VOXELS)));
    priority if ((nc_q[0] < nc_q[1]) && (nc_q[0] < nc_q[2])) begin
      pick = 2'd0;
    end else if (nc_q[1] < nc_q[2]) begin
      pick = 2'd1;
    end else begin
      pick = 2'd2;
    end
    t_sum = {1'b0, nc_q[pick]} + {1'b0, cs_q[pick]};
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ax_d        = ax_q;
    cur_d       = cur_q;
    fin_d       = fin_q;
    nc_d        = nc_q;
    cs_d        = cs_q;
    sgn_d       = sgn_q;
    adj_d       = adj_q;
    r_d         = r_q;
    cnt_d       = cnt_q;
    corner_d    = corner_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_ISSUE;
          op_d    = OP_CUR;
          ax_d    = 2'd0;
          cnt_d   = '0;
        end
      end
      S_ISSUE: begin
        if (op_q == OP_NEXT && d_zero) begin
          nc_d[ax_q] = vgrt_pkg::TIME_ALL;
          cs_d[ax_q] = vgrt_pkg::TIME_ALL;
          op_d       = OP_CUR;
          if (ax_q == 2'd2) begin
            ax_d    = 2'd0;
            state_d = S_MUL;
          end else begin
            ax_d = ax_q + 2'd1;
          end
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          state_d = S_ISSUE;
          unique case (op_q)
            OP_CUR: begin
              cur_d[ax_q] = fl_q;
              r_d         = fl_r;
              op_d        = OP_FIN;
            end
            OP_FIN: begin
              fin_d[ax_q] = fl_q;
              sgn_d[ax_q] = !d_neg;
              adj_d[ax_q] = d_neg && (cur_q[ax_q] != fl_q);
              op_d        = OP_NEXT;
            end
            OP_NEXT: begin
              nc_d[ax_q] = div_rsp.quot;
              op_d       = OP_STEP;
            end
            OP_STEP: begin
              cs_d[ax_q] = div_rsp.quot;
              op_d       = OP_CUR;
              if (ax_q == 2'd2) begin
                ax_d    = 2'd0;
                state_d = S_MUL;
              end else begin
                ax_d = ax_q + 2'd1;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        corner_d[ax_q] = corner_sat;
        if (ax_q == 2'd2) begin
          ax_d    = 2'd0;
          state_d = S_PUSH;
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.voxel_x    = corner_q[0];
          out_d.voxel_y    = corner_q[1];
          out_d.voxel_z    = corner_q[2];
          out_d.last_beat  = last_now;
          out_d.truncated  = last_now && !at_end;
          cnt_d            = cnt_q + CNT_W'(1);
          if (last_now) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_MUL;
            if (first_adj) begin
              for (int a = 0; a < 3; a++) begin
                cur_d[a] = cur_q[a] - {31'd0, adj_q[a]};
              end
            end else begin
              cur_d[pick] = sgn_q[pick] ? (cur_q[pick] + 32'd1) : (cur_q[pick] - 32'd1);
              if (nc_q[pick] != vgrt_pkg::TIME_ALL) begin
                nc_d[pick] = (t_sum > {1'b0, vgrt_pkg::TIME_FIN}) ? vgrt_pkg::TIME_FIN
                                                                   : t_sum[TW-1:0];
              end
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_CUR;
      ax_q        <= 2'd0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      size_q      <= vgrt_pkg::SIZE_RESET;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      ax_q        <= ax_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      s_q[0] <= in_data_i.start_x;
      s_q[1] <= in_data_i.start_y;
      s_q[2] <= in_data_i.start_z;
      e_q[0] <= in_data_i.end_x;
      e_q[1] <= in_data_i.end_y;
      e_q[2] <= in_data_i.end_z;
    end
    cur_q    <= cur_d;
    fin_q    <= fin_d;
    nc_q     <= nc_d;
    cs_q     <= cs_d;
    sgn_q    <= sgn_d;
    adj_q    <= adj_d;
    r_q      <= r_d;
    corner_q <= corner_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/vgrt_div.sv
// Shared restoring divider, one quotient bit per cycle.
// With frac_en the quotient carries FRAC_BITS fraction bits and saturates to TIME_FIN.
// Depends on vgrt_pkg.
module vgrt_div #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vgrt_pkg::div_req_t req_i,
  output vgrt_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W  = vgrt_pkg::NUM_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(W + 1);
  localparam int unsigned QW = vgrt_pkg::TIME_W;

  logic [W-1:0]  dvd_q, dvd_d;
  logic [31:0]   rem_q, rem_d;
  logic [31:0]   den_q, den_d;
  logic [QW-1:0] quo_q, quo_d;
  logic          ovf_q, ovf_d;
  logic          fr_q, fr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q, dvd_q[W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    fr_d   = fr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = {req_i.num, {FRAC_BITS{1'b0}}};
      rem_d  = '0;
      den_d  = req_i.den;
      quo_d  = '0;
      ovf_d  = 1'b0;
      fr_d   = req_i.frac_en;
      cnt_d  = req_i.frac_en ? CW'(W) : CW'(vgrt_pkg::NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
      quo_d = {quo_q[QW-2:0], ge};
      ovf_d = ovf_q | quo_q[QW-1];
      dvd_d = {dvd_q[W-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
    fr_q  <= fr_d;
  end

  always_comb begin
    rsp_o.done = done_q;
    rsp_o.rem  = rem_q;
    if (fr_q && (ovf_q || (&quo_q))) begin
      rsp_o.quot = vgrt_pkg::TIME_FIN;
    end else begin
      rsp_o.quot = quo_q;
    end
  end

endmodule
